// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, masked while reset is high.
`define NLP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define NLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/nlp_pkg.sv
// Shared types and constants for the numeric literal parser.
`timescale 1ns / 1ps

package nlp_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CHAR_WIDTH      = 8;
  localparam int LIMIT_WIDTH     = 64;
  localparam int OUT_WIDTH       = 64;
  localparam int STATUS_WIDTH    = 2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_INV = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_OOB = 2'd2;

  localparam logic [3:0] CL_OTHER  = 4'd0;
  localparam logic [3:0] CL_BLANK  = 4'd1;
  localparam logic [3:0] CL_END    = 4'd2;
  localparam logic [3:0] CL_ZERO   = 4'd3;
  localparam logic [3:0] CL_DOLLAR = 4'd4;
  localparam logic [3:0] CL_MINUS  = 4'd5;
  localparam logic [3:0] CL_PLUS   = 4'd6;
  localparam logic [3:0] CL_X      = 4'd7;
  localparam logic [3:0] CL_B      = 4'd8;

  typedef struct packed {
    logic       start;
    logic [3:0] code;
    logic [3:0] dval;
    logic       dig_dec;
    logic       dig_hex;
    logic       dig_bin;
  } cls_t;

endpackage

// File: rtl/core/nlp_fifo.sv
// Small synchronous queue with a register-file store.
`timescale 1ns / 1ps

module nlp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wptr;
  logic [AW:0]      rptr;

  assign empty   = (wptr == rptr);
  assign full    = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign rd_data = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wptr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (wr_en && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/nlp_front.sv
// Front end: takes characters, classifies them and saturates the limit.
`timescale 1ns / 1ps

module nlp_front import nlp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   push,
  output logic                   full,
  input  logic [CHAR_WIDTH-1:0]  char_in,
  input  logic                   start_req,
  input  logic [LIMIT_WIDTH-1:0] limit,
  input  logic                   q_full,
  output logic                   q_wr,
  output cls_t                   q_cls,
  output logic [VALUE_WIDTH-1:0] q_lim
);

  logic [CHAR_WIDTH-1:0] c;
  logic                  is_num;
  logic                  is_uhex;
  logic                  is_lhex;

  assign c       = char_in;
  assign full    = q_full;
  assign q_wr    = push && !q_full;
  assign is_num  = (c >= 8'h30) && (c <= 8'h39);
  assign is_uhex = (c >= 8'h41) && (c <= 8'h46);
  assign is_lhex = (c >= 8'h61) && (c <= 8'h66);

  always_comb begin
    q_cls.start   = start_req;
    q_cls.dig_dec = is_num;
    q_cls.dig_hex = is_num || is_uhex || is_lhex;
    q_cls.dig_bin = (c == 8'h30) || (c == 8'h31);
    if (is_uhex) begin
      q_cls.dval = 4'(c - 8'h37);
    end else if (is_lhex) begin
      q_cls.dval = 4'(c - 8'h57);
    end else begin
      q_cls.dval = 4'(c - 8'h30);
    end
    case (c)
      8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d: q_cls.code = CL_BLANK;
      8'h00, 8'h0a:                      q_cls.code = CL_END;
      8'h30:                             q_cls.code = CL_ZERO;
      8'h24:                             q_cls.code = CL_DOLLAR;
      8'h2d:                             q_cls.code = CL_MINUS;
      8'h2b:                             q_cls.code = CL_PLUS;
      8'h58:                             q_cls.code = CL_X;
      8'h42:                             q_cls.code = CL_B;
      default:                           q_cls.code = CL_OTHER;
    endcase
  end

  // clamp limit to the value range
  assign q_lim = ((limit >> VALUE_WIDTH) != '0) ? '1 : limit[VALUE_WIDTH-1:0];

endmodule

// File: rtl/core/nlp_back.sv
// Back end: parse state machine, digit accumulation and bounds checks.
`timescale 1ns / 1ps

module nlp_back import nlp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  cls_t                    in_cls,
  input  logic [VALUE_WIDTH-1:0]  in_lim,
  output logic                    in_take,
  input  logic                    res_full,
  output logic                    res_push,
  output logic [VALUE_WIDTH-1:0]  res_value,
  output logic [STATUS_WIDTH-1:0] res_status
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_ZERO   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_HEX = 2'd1;
  localparam logic [1:0] RX_BIN = 2'd2;

  logic [1:0]             phase, phase_next;
  logic [1:0]             radix_sel, radix_sel_next;
  logic                   is_negative, is_negative_next;
  logic [VALUE_WIDTH-1:0] accumulator, accumulator_next;
  logic [VALUE_WIDTH-1:0] active_limit, active_limit_next;
  logic                   digit_seen, digit_seen_next;

  logic [1:0]             e_phase;
  logic                   e_neg;
  logic [VALUE_WIDTH-1:0] e_acc;
  logic [VALUE_WIDTH-1:0] e_lim;
  logic                   e_seen;
  logic                   dc_en;
  logic [1:0]             dc_rx;
  logic                   dc_seen;
  logic                   dc_dig;
  logic [VALUE_WIDTH+3:0] prod;
  logic [VALUE_WIDTH:0]   sum;
  logic                   emit;

  assign in_take  = in_valid && !res_full;
  assign res_push = in_take && emit;

  always_comb begin
    e_phase = in_cls.start ? PH_SKIP : phase;
    e_neg   = in_cls.start ? 1'b0 : is_negative;
    e_acc   = in_cls.start ? '0 : accumulator;
    e_lim   = in_cls.start ? in_lim : active_limit;
    e_seen  = in_cls.start ? 1'b0 : digit_seen;

    phase_next        = e_phase;
    radix_sel_next    = in_cls.start ? RX_DEC : radix_sel;
    is_negative_next  = e_neg;
    accumulator_next  = e_acc;
    active_limit_next = e_lim;
    digit_seen_next   = e_seen;

    dc_en      = 1'b0;
    dc_rx      = radix_sel_next;
    dc_seen    = e_seen;
    emit       = 1'b0;
    res_value  = '0;
    res_status = ST_OK;

    case (e_phase)
      PH_SKIP: begin
        if (in_cls.code == CL_BLANK) begin
          phase_next = PH_SKIP;
        end else if (in_cls.code == CL_END) begin
          emit       = 1'b1;
          res_status = ST_INV;
        end else if (in_cls.code == CL_ZERO) begin
          phase_next = PH_ZERO;
        end else if (in_cls.code == CL_DOLLAR) begin
          radix_sel_next = RX_HEX;
          phase_next     = PH_DIGITS;
        end else begin
          radix_sel_next = RX_DEC;
          phase_next     = PH_DIGITS;
          if (in_cls.code == CL_MINUS) begin
            is_negative_next  = 1'b1;
            active_limit_next = (e_lim >> 1) + 1'b1;
          end else if (in_cls.code != CL_PLUS) begin
            dc_en = 1'b1;
            dc_rx = RX_DEC;
          end
        end
      end
      PH_ZERO: begin
        phase_next = PH_DIGITS;
        if (in_cls.code == CL_X) begin
          radix_sel_next = RX_HEX;
        end else if (in_cls.code == CL_B) begin
          radix_sel_next = RX_BIN;
        end else begin
          radix_sel_next   = RX_DEC;
          accumulator_next = '0;
          digit_seen_next  = 1'b1;
          dc_seen          = 1'b1;
          dc_en            = 1'b1;
          dc_rx            = RX_DEC;
        end
      end
      PH_DIGITS: begin
        dc_en = 1'b1;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    case (dc_rx)
      RX_HEX: begin
        dc_dig = in_cls.dig_hex;
        prod   = {e_acc, 4'b0000};
      end
      RX_BIN: begin
        dc_dig = in_cls.dig_bin;
        prod   = {3'b000, e_acc, 1'b0};
      end
      default: begin
        dc_dig = in_cls.dig_dec;
        prod   = {1'b0, e_acc, 3'b000} + {3'b000, e_acc, 1'b0};
      end
    endcase
    sum = {1'b0, prod[VALUE_WIDTH-1:0]} + (VALUE_WIDTH+1)'(in_cls.dval);

    if (dc_en) begin
      if (!dc_dig) begin
        emit = 1'b1;
        if (dc_seen) begin
          res_value = e_neg ? ('0 - e_acc) : e_acc;
        end else begin
          res_status = ST_INV;
        end
      end else if (prod[VALUE_WIDTH+3:VALUE_WIDTH] != 4'b0000) begin
        emit       = 1'b1;
        res_status = ST_OOB;
        res_value  = e_acc;
      end else if (sum[VALUE_WIDTH]) begin
        emit       = 1'b1;
        res_status = ST_OOB;
        res_value  = prod[VALUE_WIDTH-1:0];
      end else if (sum[VALUE_WIDTH-1:0] > e_lim) begin
        emit       = 1'b1;
        res_status = ST_OOB;
        res_value  = sum[VALUE_WIDTH-1:0];
      end else begin
        accumulator_next = sum[VALUE_WIDTH-1:0];
        digit_seen_next  = 1'b1;
      end
    end

    if (emit) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      radix_sel    <= RX_DEC;
      is_negative  <= 1'b0;
      accumulator  <= '0;
      active_limit <= '0;
      digit_seen   <= 1'b0;
    end else if (in_take) begin
      phase        <= phase_next;
      radix_sel    <= radix_sel_next;
      is_negative  <= is_negative_next;
      accumulator  <= accumulator_next;
      active_limit <= active_limit_next;
      digit_seen   <= digit_seen_next;
    end
  end

endmodule

// File: rtl/core/numeric_literal_parser.sv
// Top level of the numeric literal parser.
//
// Input side is a queue: drive char_in, start_req and limit with push; a
// request is taken at a clock edge where push is high and full is low.
// start_req marks the first character of a literal and samples limit.
// Output side is a queue: while empty is low, value and status show the
// oldest result; pop at a clock edge with empty low takes it.
// Status: 0 ok, 1 invalid, 2 out of bounds. At most one result per
// character, on the character that ends a literal or breaks a bound.
// Throughput is one character per cycle while full is low, set by the
// combinational accumulate/compare in the back end. A result is visible
// once it has passed the middle queue and entered the output queue.
// Queues of QUEUE_DEPTH entries sit between front and back and on the
// output; a stalled receiver fills the output queue, then the middle one,
// then full goes high. Synchronous reset empties both queues and returns
// the parser to idle; characters without start_req are then dropped.
`timescale 1ns / 1ps

module numeric_literal_parser import nlp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [CHAR_WIDTH-1:0]   char_in,
  input  logic                    start_req,
  input  logic [LIMIT_WIDTH-1:0]  limit,
  output logic                    empty,
  input  logic                    pop,
  output logic [OUT_WIDTH-1:0]    value,
  output logic [STATUS_WIDTH-1:0] status
);

  localparam int MID_W = $bits(cls_t) + VALUE_WIDTH;
  localparam int RES_W = VALUE_WIDTH + STATUS_WIDTH;

  logic                    q_wr;
  cls_t                    q_cls;
  logic [VALUE_WIDTH-1:0]  q_lim;
  logic                    mid_full;
  logic                    mid_empty;
  logic [MID_W-1:0]        mid_rd;
  logic                    mid_take;
  cls_t                    b_cls;
  logic [VALUE_WIDTH-1:0]  b_lim;
  logic                    res_full;
  logic                    res_push;
  logic [VALUE_WIDTH-1:0]  res_value;
  logic [STATUS_WIDTH-1:0] res_status;
  logic [RES_W-1:0]        out_rd;

  nlp_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .push      (push),
    .full      (full),
    .char_in   (char_in),
    .start_req (start_req),
    .limit     (limit),
    .q_full    (mid_full),
    .q_wr      (q_wr),
    .q_cls     (q_cls),
    .q_lim     (q_lim)
  );

  nlp_fifo #(.WIDTH(MID_W), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data ({q_cls, q_lim}),
    .rd_en   (mid_take),
    .rd_data (mid_rd),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  assign b_cls = mid_rd[MID_W-1:VALUE_WIDTH];
  assign b_lim = mid_rd[VALUE_WIDTH-1:0];

  nlp_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!mid_empty),
    .in_cls     (b_cls),
    .in_lim     (b_lim),
    .in_take    (mid_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_value  (res_value),
    .res_status (res_status)
  );

  nlp_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data ({res_status, res_value}),
    .rd_en   (pop),
    .rd_data (out_rd),
    .full    (res_full),
    .empty   (empty)
  );

  assign status = out_rd[RES_W-1:VALUE_WIDTH];
  assign value  = OUT_WIDTH'(out_rd[VALUE_WIDTH-1:0]);

endmodule

// File: rtl/core/nlp_checker.sv
// Port-level checks for the numeric literal parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nlp_checker import nlp_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    empty,
  input logic                    pop,
  input logic [OUT_WIDTH-1:0]    value,
  input logic [STATUS_WIDTH-1:0] status
);

  `NLP_ASSERT_ALWAYS(a_empty_after_rst, clk, $past(rst) |-> empty, "result shown after reset")

  `NLP_ASSERT(a_status_code, clk, rst, !empty |-> (status == ST_OK || status == ST_INV || status == ST_OOB), "bad status code")

  `NLP_ASSERT(a_inv_zero, clk, rst, (!empty && status == ST_INV) |-> value == '0, "invalid result with nonzero value")

  `NLP_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(value) && $stable(status)), "waiting result changed")

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .value  (value),
  .status (status)
);

// File: tb/numeric_literal_parser_tb.sv
// Self-checking testbench for numeric_literal_parser: a scoreboard predicts each literal result.
`timescale 1ns / 1ps

module numeric_literal_parser_tb import nlp_pkg::*; ();

  localparam int          CYCLE_LIMIT = 500000;
  localparam logic [63:0] ALL_ONES    = '1;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UB      = 8'h42;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_UX      = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_TOP     = 8'hFF;

  typedef enum logic [1:0] {PH_IDLE, PH_SKIP, PH_ZERO, PH_DIGITS} parse_phase_e;
  typedef enum logic [1:0] {RX_DEC, RX_HEX, RX_BIN} radix_e;

  class literal_scoreboard;
    parse_phase_e phase;
    radix_e       radix;
    bit           neg;
    bit           seen;
    logic [63:0]  acc;
    logic [63:0]  bound;
    logic [63:0]  value_q[$];
    logic [1:0]   status_q[$];
    int           errors;
    int           requests;
    int           results;
    int           n_ok;
    int           n_inv;
    int           n_oob;

    function new();
      clear();
      errors = 0;
      requests = 0;
      results = 0;
      n_ok = 0;
      n_inv = 0;
      n_oob = 0;
    endfunction

    function void clear();
      phase = PH_IDLE;
      radix = RX_DEC;
      neg = 1'b0;
      seen = 1'b0;
      acc = '0;
      bound = '0;
    endfunction

    function int pending();
      return value_q.size();
    endfunction

    function void post(logic [63:0] v, logic [1:0] st);
      value_q.push_back(v);
      status_q.push_back(st);
      phase = PH_IDLE;
    endfunction

    function bit digit_of(input logic [7:0] c, output logic [63:0] d);
      digit_of = 1'b1;
      d = '0;
      if (c >= CH_ZERO && c <= CH_NINE && (radix != RX_BIN || c <= CH_ONE))
        d = 64'(c - CH_ZERO);
      else if (radix == RX_HEX && c >= CH_UA && c <= CH_UF)
        d = 64'(c - CH_UA) + 64'd10;
      else if (radix == RX_HEX && c >= CH_LOWER_A && c <= CH_LOWER_F)
        d = 64'(c - CH_LOWER_A) + 64'd10;
      else digit_of = 1'b0;
    endfunction

    function void digit_step(logic [7:0] c);
      logic [63:0] d;
      logic [63:0] r;
      logic [63:0] a;
      if (!digit_of(c, d)) begin
        if (!seen) post('0, ST_INV);
        else post(neg ? 64'd0 - acc : acc, ST_OK);
        return;
      end
      r = (radix == RX_HEX) ? 64'd16 : (radix == RX_BIN) ? 64'd2 : 64'd10;
      a = acc;
      if (a != 0 && ALL_ONES / a < r) begin
        post(a, ST_OOB);
        return;
      end
      a = a * r;
      if (ALL_ONES - a < d) begin
        post(a, ST_OOB);
        return;
      end
      a = a + d;
      if (a > bound) begin
        post(a, ST_OOB);
        return;
      end
      acc = a;
      seen = 1'b1;
    endfunction

    // Called for every accepted request.
    function void note_request(logic [7:0] c, logic s, logic [63:0] lim);
      requests++;
      if (s) begin
        clear();
        bound = lim;
        phase = PH_SKIP;
      end
      case (phase)
        PH_SKIP: begin
          if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR) begin
          end else if (c == CH_NUL || c == CH_LF) begin
            post('0, ST_INV);
          end else if (c == CH_ZERO) begin
            phase = PH_ZERO;
          end else if (c == CH_DOLLAR) begin
            radix = RX_HEX;
            phase = PH_DIGITS;
          end else begin
            radix = RX_DEC;
            phase = PH_DIGITS;
            if (c == CH_MINUS) begin
              neg = 1'b1;
              bound = bound / 64'd2 + 64'd1;
            end else if (c != CH_PLUS) begin
              digit_step(c);
            end
          end
        end
        PH_ZERO: begin
          phase = PH_DIGITS;
          if (c == CH_UX) begin
            radix = RX_HEX;
          end else if (c == CH_UB) begin
            radix = RX_BIN;
          end else begin
            radix = RX_DEC;
            acc = '0;
            seen = 1'b1;
            digit_step(c);
          end
        end
        PH_DIGITS: digit_step(c);
        default: ;
      endcase
    endfunction

    function void check_result(logic [63:0] v, logic [1:0] st);
      logic [63:0] ev;
      logic [1:0]  es;
      results++;
      if (value_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual value %h status %0d",
                 $time, v, st);
        return;
      end
      ev = value_q.pop_front();
      es = status_q.pop_front();
      if (es == ST_OK) n_ok++;
      else if (es == ST_INV) n_inv++;
      else n_oob++;
      if (v !== ev) begin
        errors++;
        $display("%0t: value mismatch: expected %h, actual %h", $time, ev, v);
      end
      if (st !== es) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, es, st);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    push      = 1'b0;
  logic                    full;
  logic [CHAR_WIDTH-1:0]   char_in   = '0;
  logic                    start_req = 1'b0;
  logic [LIMIT_WIDTH-1:0]  limit     = '0;
  logic                    empty;
  logic                    pop       = 1'b0;
  logic [OUT_WIDTH-1:0]    value;
  logic [STATUS_WIDTH-1:0] status;

  literal_scoreboard sb = new();
  int send_idle = 24;
  int recv_idle = 86;
  int cycles = 0;

  numeric_literal_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_in   (char_in),
    .start_req (start_req),
    .limit     (limit),
    .empty     (empty),
    .pop       (pop),
    .value     (value),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(value, status);
    pop <= !rst && ($urandom_range(99) >= recv_idle);
  end

  task automatic put_char(logic [7:0] c, logic s, logic [63:0] lim);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    char_in <= c;
    start_req <= s;
    limit <= lim;
    do @(posedge clk); while (full);
    sb.note_request(c, s, lim);
  endtask

  task automatic send_string(string s, logic [63:0] lim);
    for (int i = 0; i < s.len(); i++) put_char(s[i], i == 0, lim);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_limit();
    case ($urandom_range(3))
      0: return ALL_ONES;
      1: return {$urandom, $urandom};
      2: return 64'($urandom_range(1000));
      default: return {$urandom, $urandom} >> $urandom_range(63);
    endcase
  endfunction

  function automatic logic [7:0] rand_digit(radix_e rx);
    if (rx == RX_BIN) return CH_ZERO + 8'($urandom_range(1));
    if (rx == RX_DEC) return CH_ZERO + 8'($urandom_range(9));
    case ($urandom_range(2))
      0: return CH_ZERO + 8'($urandom_range(9));
      1: return CH_UA + 8'($urandom_range(5));
      default: return CH_LOWER_A + 8'($urandom_range(5));
    endcase
  endfunction

  task automatic rand_literal();
    logic [7:0]  chars[$];
    logic [63:0] lim;
    radix_e      rx;
    int          ndig;
    int          longest;
    lim = rand_limit();
    rx = RX_DEC;
    repeat ($urandom_range(2)) begin
      case ($urandom_range(4))
        0: chars.push_back(CH_SPACE);
        1: chars.push_back(CH_TAB);
        2: chars.push_back(CH_VT);
        3: chars.push_back(CH_FF);
        default: chars.push_back(CH_CR);
      endcase
    end
    case ($urandom_range(6))
      0: begin chars.push_back(CH_ZERO); chars.push_back(CH_UX); rx = RX_HEX; end
      1: begin chars.push_back(CH_DOLLAR); rx = RX_HEX; end
      2: begin chars.push_back(CH_ZERO); chars.push_back(CH_UB); rx = RX_BIN; end
      3: chars.push_back(CH_MINUS);
      4: chars.push_back(CH_PLUS);
      5: chars.push_back(CH_ZERO);
      default: ;
    endcase
    longest = (rx == RX_HEX) ? 18 : (rx == RX_BIN) ? 66 : 21;
    ndig = ($urandom_range(99) < 15) ? $urandom_range(longest) : $urandom_range(6);
    repeat (ndig) chars.push_back(rand_digit(rx));
    case ($urandom_range(4))
      0: chars.push_back(CH_SPACE);
      1: chars.push_back(CH_NUL);
      2: chars.push_back(CH_LF);
      3: chars.push_back(CH_COMMA);
      default: chars.push_back(8'($urandom_range(255)));
    endcase
    // abandoned literal: cut short, the next start takes over
    if ($urandom_range(19) == 0) chars = chars[0:$urandom_range(chars.size() - 1)];
    foreach (chars[i]) put_char(chars[i], i == 0, lim);
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(255)), 1'b0, {$urandom, $urandom});
  endtask

  task automatic run_random(int target);
    while (sb.requests < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6))
          put_char(8'($urandom_range(255)), $urandom_range(3) == 0, rand_limit());
      end else begin
        rand_literal();
      end
      if ($urandom_range(199) == 0) wait_drained();
    end
  endtask

  task automatic run_directed();
    send_string("0X1F,", ALL_ONES);
    send_string("$fF ", ALL_ONES);
    send_string("0B101;", ALL_ONES);
    send_string("-123 ", ALL_ONES);
    send_string("+42\n", ALL_ONES);
    put_char(CH_TAB, 1'b1, ALL_ONES);
    put_char(CH_VT, 1'b0, ALL_ONES);
    put_char(CH_FF, 1'b0, ALL_ONES);
    put_char(CH_CR, 1'b0, ALL_ONES);
    put_char(CH_NINE, 1'b0, ALL_ONES);
    put_char(CH_NUL, 1'b0, ALL_ONES);
    send_string("\n", ALL_ONES);
    put_char(CH_NUL, 1'b1, ALL_ONES);
    send_string("0X ", ALL_ONES);
    send_string("$;", ALL_ONES);
    send_string("- ", ALL_ONES);
    send_string("0 ", ALL_ONES);
    send_string("007,", ALL_ONES);
    send_string("0B2", ALL_ONES);
    send_string("0A", ALL_ONES);
    send_string("18446744073709551615 ", ALL_ONES);
    send_string("18446744073709551616 ", ALL_ONES);
    send_string("184467440737095516150 ", ALL_ONES);
    send_string("0XFFFFFFFFFFFFFFFFF ", ALL_ONES);
    send_string("-9223372036854775808 ", ALL_ONES);
    send_string("101 ", 64'd100);
    send_string("-51 ", 64'd100);
    send_string("-52 ", 64'd100);
    send_string("0 ", 64'd0);
    send_string("1 ", 64'd0);
    send_string("12", ALL_ONES);
    send_string("5 ", ALL_ONES);
    put_char(CH_ONE, 1'b0, ALL_ONES);
    put_char(CH_NINE, 1'b0, '0);
    send_string("3", ALL_ONES);
    put_char(CH_TOP, 1'b0, ALL_ONES);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    wait_drained();
    run_random(sb.requests + 375);
    wait_drained();
    send_idle = 86;
    recv_idle = 24;
    run_random(sb.requests + 375);
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    run_random(sb.requests + 375);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d characters under three idling mixes; checked %0d results",
             sb.requests, sb.results);
    $display("Results by status: %0d ok, %0d invalid, %0d out of bounds; %0d errors",
             sb.n_ok, sb.n_inv, sb.n_oob, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
